### src/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/cgs_pkg.sv
`timescale 1ns / 1ps

package cgs_pkg;

	localparam int CODE_W  = 8;
	localparam int POS_W   = 3;
	localparam int RULES_W = 30;
	localparam int ADDR_W  = 2;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	localparam logic [POS_W-1:0] POS_LEFT  = 3'd0;
	localparam logic [POS_W-1:0] POS_RIGHT = 3'd1;
	localparam logic [POS_W-1:0] POS_BOTH  = 3'd2;
	localparam logic [POS_W-1:0] POS_NONE  = 3'd3;
	localparam logic [POS_W-1:0] POS_SKIP  = 3'd4;

	localparam logic FUNC_SHAPE = 1'b0;
	localparam logic FUNC_LOAD  = 1'b1;

	localparam logic [ADDR_W-1:0] REG_FIRST  = 2'd0;
	localparam logic [ADDR_W-1:0] REG_SECOND = 2'd1;

	localparam logic [CODE_W-1:0] BLANK_CODE = 8'h20;

	typedef struct packed {
		logic [CODE_W-1:0] glyph;
		logic [POS_W-1:0]  pos;
		logic              in_table;
		logic              last;
	} res_t;

	function automatic logic [POS_W-1:0] rule_at(input logic [RULES_W-1:0] rules,
		input logic [3:0] k);
		logic [POS_W-1:0] r;
		r = rules[3*k +: 3];
		return (r > POS_SKIP) ? POS_SKIP : r;
	endfunction

	function automatic logic [CODE_W-1:0] form_of(input logic [CODE_W-1:0] code,
		input logic [POS_W-1:0] pos, input logic [31:0] form);
		logic [CODE_W-1:0] g;
		case (pos)
			POS_LEFT:  g = form[7:0];
			POS_RIGHT: g = form[15:8];
			POS_BOTH:  g = form[23:16];
			POS_NONE:  g = code;
			default:   g = form[31:24];
		endcase
		return g;
	endfunction

	function automatic res_t emit(input logic [CODE_W-1:0] code, input logic present,
		input logic [31:0] form, input logic next_present, input logic [POS_W-1:0] prev,
		input logic [RULES_W-1:0] first, input logic [RULES_W-1:0] second);
		res_t             r;
		logic [POS_W-1:0] p;
		logic [3:0]       k;
		logic [POS_W-1:0] d;
		logic [POS_W-1:0] e;
		logic [POS_W-1:0] f;
		p = (prev > POS_SKIP) ? POS_SKIP : prev;
		k = {p, ~next_present};
		d = rule_at(first, k);
		e = rule_at(second, k);
		f = (form_of(code, d, form) == '0) ? e : d;
		r.last = 1'b0;
		if (!present) begin
			r.glyph    = code;
			r.pos      = POS_SKIP;
			r.in_table = 1'b0;
		end else begin
			r.glyph    = form_of(code, f, form);
			r.pos      = f;
			r.in_table = 1'b1;
		end
		return r;
	endfunction

endpackage

### src/cgs_ifs.sv
`timescale 1ns / 1ps

interface cgs_in_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [cgs_pkg::CODE_W-1:0] char_code;
	logic [cgs_pkg::CODE_W-1:0] form_left;
	logic [cgs_pkg::CODE_W-1:0] form_right;
	logic [cgs_pkg::CODE_W-1:0] form_both;
	logic [cgs_pkg::CODE_W-1:0] form_skip;
	logic                      end_of_line;

	modport source (output valid, func, char_code, form_left, form_right, form_both,
		form_skip, end_of_line, input ready);
	modport sink (input valid, func, char_code, form_left, form_right, form_both,
		form_skip, end_of_line, output ready);
endinterface

interface cgs_out_if;
	logic                      valid;
	logic                      ready;
	logic [cgs_pkg::CODE_W-1:0] glyph_code;
	logic [cgs_pkg::POS_W-1:0]  position;
	logic                      in_table;
	logic                      line_last;

	modport source (output valid, glyph_code, position, in_table, line_last, input ready);
	modport sink (input valid, glyph_code, position, in_table, line_last, output ready);
endinterface

interface cgs_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cgs_pkg::ADDR_W-1:0]  addr;
	logic [cgs_pkg::RULES_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

### src/contextual_glyph_shaper.sv
// Positional glyph shaper. One request (a character or a form load) is taken
// every cycle while the input register is free to take it. A character comes out
// one character later, once the following character is known. An end-of-line
// character also releases itself, so it can produce two results. A form load
// writes the 256-entry form memory and the presence bits in the cycle it is
// taken. A character reads both as it is taken into the input register. From
// there it is shaped combinationally into a four-entry result queue that drives
// the output. The input register moves on only while that queue holds at most
// two results. A new request is taken while the input register is empty or
// moving on. The sustained rate is one request per cycle while the output drains
// one result per cycle. Apart from output stalls, the only throttle is two
// results from one end-of-line request. The form memory needs no clearing pass:
// presence bits are cleared at reset, and an entry is written exactly once, by the
// first load for its code. Rule registers are written with no wait state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module contextual_glyph_shaper (
	input  logic      clk,
	input  logic      arst_n,
	cgs_cfg_if.sink   cfg,
	cgs_in_if.sink    din,
	cgs_out_if.source dout
);

	logic [cgs_pkg::RULES_W-1:0] first_q;
	logic [cgs_pkg::RULES_W-1:0] second_q;
	logic [255:0]                present_q;
	logic [31:0]                 form_mem [256];
	logic [cgs_pkg::CODE_W-1:0]  held_code_q;
	logic                        held_valid_q;
	logic [cgs_pkg::POS_W-1:0]   prev_q;

	logic                        valid_s1;
	logic                        held_valid_s1;
	logic [cgs_pkg::CODE_W-1:0]  held_code_s1;
	logic                        held_present_s1;
	logic [31:0]                 held_form_s1;
	logic [cgs_pkg::CODE_W-1:0]  cur_code_s1;
	logic                        cur_present_s1;
	logic [31:0]                 cur_form_s1;
	logic                        cur_eol_s1;
	logic                        blank_present_s1;

	cgs_pkg::res_t               queue_q [cgs_pkg::QDEPTH];
	logic [cgs_pkg::QPTR_W-1:0]  wr_q;
	logic [cgs_pkg::QPTR_W-1:0]  rd_q;
	logic [cgs_pkg::QCNT_W-1:0]  cnt_q;

	logic                        accept;
	logic                        accept_shape;
	logic                        load_we;
	logic                        fire_s1;
	logic                        pop;
	logic [1:0]                  push_n;
	cgs_pkg::res_t               res0;
	cgs_pkg::res_t               res1;
	logic [cgs_pkg::POS_W-1:0]   prev_mid;

	assign cfg.ready    = 1'b1;
	assign fire_s1      = valid_s1 && (cnt_q <= cgs_pkg::QCNT_W'(cgs_pkg::QDEPTH - 2));
	assign din.ready    = !valid_s1 || fire_s1;
	assign accept       = din.valid && din.ready;
	assign accept_shape = accept && (din.func == cgs_pkg::FUNC_SHAPE);
	assign load_we      = accept && (din.func == cgs_pkg::FUNC_LOAD) &&
		!present_q[din.char_code];
	assign pop          = dout.valid && dout.ready;
	assign push_n       = fire_s1 ? (2'(held_valid_s1) + 2'(cur_eol_s1)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.addr)
				cgs_pkg::REG_FIRST:  first_q  <= cfg.data;
				cgs_pkg::REG_SECOND: second_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_we)
			form_mem[din.char_code] <= {din.form_skip, din.form_both, din.form_right,
				din.form_left};
		if (accept_shape) begin
			held_form_s1 <= form_mem[held_code_q];
			cur_form_s1  <= form_mem[din.char_code];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			held_code_q  <= '0;
			held_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (load_we)
				present_q[din.char_code] <= 1'b1;
			if (accept_shape) begin
				held_code_q  <= din.end_of_line ? '0 : din.char_code;
				held_valid_q <= !din.end_of_line;
			end
			if (din.ready)
				valid_s1 <= accept_shape;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_shape) begin
			held_valid_s1    <= held_valid_q;
			held_code_s1     <= held_code_q;
			held_present_s1  <= present_q[held_code_q];
			cur_code_s1      <= din.char_code;
			cur_present_s1   <= present_q[din.char_code];
			cur_eol_s1       <= din.end_of_line;
			blank_present_s1 <= present_q[cgs_pkg::BLANK_CODE];
		end
	end

	always_comb begin
		res0      = cgs_pkg::emit(held_code_s1, held_present_s1, held_form_s1, cur_present_s1,
			prev_q, first_q, second_q);
		prev_mid  = held_valid_s1 ? res0.pos : prev_q;
		res1      = cgs_pkg::emit(cur_code_s1, cur_present_s1, cur_form_s1, blank_present_s1,
			prev_mid, first_q, second_q);
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= cgs_pkg::POS_SKIP;
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (fire_s1) begin
				prev_q <= cur_eol_s1 ? cgs_pkg::POS_SKIP : prev_mid;
				wr_q   <= wr_q + push_n;
			end
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + cgs_pkg::QCNT_W'(push_n) - cgs_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			if (held_valid_s1)
				queue_q[wr_q] <= res0;
			if (cur_eol_s1)
				queue_q[wr_q + 2'(held_valid_s1)] <= res1;
		end
	end

	assign dout.valid      = (cnt_q != '0);
	assign dout.glyph_code = queue_q[rd_q].glyph;
	assign dout.position   = queue_q[rd_q].pos;
	assign dout.in_table   = queue_q[rd_q].in_table;
	assign dout.line_last  = queue_q[rd_q].last;

	`ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= cgs_pkg::QCNT_W'(cgs_pkg::QDEPTH))
	`ASSERT_NOW(a_prev_range, 1'b1, prev_q <= cgs_pkg::POS_SKIP)
	`ASSERT_NEXT(a_eol_drops_held, accept_shape && din.end_of_line, !held_valid_q)
	`ASSERT_NOW(a_out_pos_range, dout.valid, dout.position <= cgs_pkg::POS_SKIP)

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import cgs_pkg::*;

	localparam int IDLE_PCT      = 10;
	localparam int DRAIN_CYCLES  = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_ITEMS = 150;

	localparam logic [ADDR_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [ADDR_W-1:0] REG_UNUSED_B = 2'd3;

	localparam res_t NO_RES = '0;

	typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e           kind;
		logic                func;
		logic [CODE_W-1:0]   code;
		logic [31:0]         forms;
		logic                eol;
		logic [ADDR_W-1:0]   addr;
		logic [RULES_W-1:0]  data;
		bit                  known;
		res_t                want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cgs_cfg_if cfg ();
	cgs_in_if  din ();
	cgs_out_if dout ();

	contextual_glyph_shaper uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.din(din),
		.dout(dout)
	);

	always #1 clk = ~clk;

	logic [31:0]        form_mem [256];
	bit                 form_loaded [256];
	logic [CODE_W-1:0]  held_char;
	bit                 held;
	logic [POS_W-1:0]   prior_pos;
	logic [RULES_W-1:0] first_rules;
	logic [RULES_W-1:0] second_rules;
	res_t               glyph_queue [$];
	res_t               newest;

	int  errors    = 0;
	int  n_shaped  = 0;
	int  n_loads   = 0;
	int  n_writes  = 0;
	int  n_checked = 0;
	int  quiet     = 0;
	bit  steady    = 1'b0;

	stim_row_t script [$];

	function automatic logic [POS_W-1:0] rule_pick(input logic [RULES_W-1:0] rules,
		input int idx);
		logic [POS_W-1:0] r;
		r = rules[3*idx +: 3];
		return (r > POS_SKIP) ? POS_SKIP : r;
	endfunction

	function automatic logic [CODE_W-1:0] glyph_for(input logic [CODE_W-1:0] code,
		input logic [POS_W-1:0] pos);
		logic [31:0] forms;
		forms = form_mem[code];
		if (pos == POS_NONE)
			return code;
		if (pos == POS_SKIP)
			return forms[31:24];
		return forms[8*int'(pos) +: 8];
	endfunction

	function automatic void release_char(input logic [CODE_W-1:0] code,
		input logic [CODE_W-1:0] next_code, input bit last);
		res_t             r;
		logic [POS_W-1:0] pick;
		logic [POS_W-1:0] fallback;
		int               idx;
		if (!form_loaded[code]) begin
			r = '{code, POS_SKIP, 1'b0, last};
		end else begin
			idx = 2 * int'(prior_pos) + (form_loaded[next_code] ? 0 : 1);
			pick = rule_pick(first_rules, idx);
			fallback = rule_pick(second_rules, idx);
			if (glyph_for(code, pick) == '0)
				pick = fallback;
			r = '{glyph_for(code, pick), pick, 1'b1, last};
		end
		prior_pos = r.pos;
		glyph_queue.push_back(r);
		newest = r;
	endfunction

	function automatic void take_request(input logic func, input logic [CODE_W-1:0] code,
		input logic [31:0] forms, input logic eol);
		if (func == FUNC_LOAD) begin
			n_loads++;
			if (!form_loaded[code]) begin
				form_loaded[code] = 1'b1;
				form_mem[code] = forms;
			end
		end else begin
			n_shaped++;
			if (held)
				release_char(held_char, code, 1'b0);
			if (eol) begin
				release_char(code, BLANK_CODE, 1'b1);
				held = 1'b0;
				held_char = '0;
				prior_pos = POS_SKIP;
			end else begin
				held_char = code;
				held = 1'b1;
			end
		end
	endfunction

	function automatic logic [RULES_W-1:0] random_rules();
		logic [RULES_W-1:0] v;
		v = RULES_W'($urandom());
		if ($urandom_range(0, 1) == 1)
			for (int i = 0; i < 10; i++)
				v[3*i +: 3] = POS_W'($urandom_range(0, 4));
		return v;
	endfunction

	function automatic logic [CODE_W-1:0] random_form();
		return ($urandom_range(0, 3) == 0) ? '0 : CODE_W'($urandom_range(0, 255));
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	task automatic send_request(input logic func, input logic [CODE_W-1:0] code,
		input logic [31:0] forms, input logic eol);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid       <= 1'b1;
		din.func        <= func;
		din.char_code   <= code;
		din.form_left   <= forms[7:0];
		din.form_right  <= forms[15:8];
		din.form_both   <= forms[23:16];
		din.form_skip   <= forms[31:24];
		din.end_of_line <= eol;
		// hold the request until it is taken
		do @(posedge clk); while (!din.ready);
		take_request(func, code, forms, eol);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [RULES_W-1:0] data);
		din.valid <= 1'b0;
		// drain before touching the rules
		while (glyph_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.addr  <= addr;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		n_writes++;
		if (addr == REG_FIRST)
			first_rules = data;
		else if (addr == REG_SECOND)
			second_rules = data;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		dout.ready = 1'b0;
		forever begin
			@(negedge clk);
			dout.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && dout.valid && dout.ready) begin
			if (glyph_queue.size() == 0) begin
				errors++;
				$display("%0t unexpected result: glyph %0h position %0d in_table %0b last %0b",
					$time, dout.glyph_code, dout.position, dout.in_table, dout.line_last);
			end else begin
				want = glyph_queue.pop_front();
				n_checked++;
				check_field("glyph_code", want.glyph, dout.glyph_code);
				check_field("position", want.pos, dout.position);
				check_field("in_table", want.in_table, dout.in_table);
				check_field("line_last", want.last, dout.line_last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (din.valid && din.ready) || (dout.valid && dout.ready)
			|| (cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("%0t no progress for %0d cycles", $time, quiet);
			$display("tb failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		stim_row_t          row;
		logic [CODE_W-1:0]  code;
		logic [RULES_W-1:0] rules_a;
		logic [RULES_W-1:0] rules_b;
		int                 pick;

		arst_n          = 1'b0;
		din.valid       = 1'b0;
		din.func        = FUNC_SHAPE;
		din.char_code   = '0;
		din.form_left   = '0;
		din.form_right  = '0;
		din.form_both   = '0;
		din.form_skip   = '0;
		din.end_of_line = 1'b0;
		cfg.valid       = 1'b0;
		cfg.addr        = REG_FIRST;
		cfg.data        = '0;

		foreach (form_mem[i]) begin
			form_mem[i] = '0;
			form_loaded[i] = 1'b0;
		end
		held = 1'b0;
		held_char = '0;
		prior_pos = POS_SKIP;
		first_rules = '0;
		second_rules = '0;
		newest = NO_RES;

		script = '{
			'{ROW_REQ, FUNC_SHAPE, 8'h00, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h00, POS_SKIP, 1'b0, 1'b1}},
			'{ROW_REQ, FUNC_SHAPE, 8'hFF, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'hFF, POS_SKIP, 1'b0, 1'b1}},
			'{ROW_REQ, FUNC_LOAD, 8'h41, 32'h04030201, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_LOAD, 8'h41, 32'hAAAAAAAA, 1'b1, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h41, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h01, POS_LEFT, 1'b1, 1'b1}},
			'{ROW_REQ, FUNC_LOAD, 8'h42, 32'h14131200, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h42, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h00, POS_LEFT, 1'b1, 1'b1}},
			'{ROW_REQ, FUNC_LOAD, 8'hFF, 32'hFFFFFFFF, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_LOAD, 8'h20, 32'h24232221, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h41, 32'h0, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'hFF, 32'h0, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h30, 32'h0, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h42, 32'h0, 1'b1, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REG, FUNC_SHAPE, 8'h00, 32'h0, 1'b0, REG_FIRST, '1, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h41, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h04, POS_SKIP, 1'b1, 1'b1}},
			'{ROW_REG, FUNC_SHAPE, 8'h00, 32'h0, 1'b0, REG_SECOND, '1, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_LOAD, 8'h43, 32'h00002200, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h43, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h00, POS_SKIP, 1'b1, 1'b1}},
			'{ROW_REG, FUNC_SHAPE, 8'h00, 32'h0, 1'b0, REG_FIRST, {10{POS_NONE}}, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h41, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h41, POS_NONE, 1'b1, 1'b1}},
			'{ROW_REG, FUNC_SHAPE, 8'h00, 32'h0, 1'b0, REG_UNUSED_A, '0, 1'b0, NO_RES},
			'{ROW_REG, FUNC_SHAPE, 8'h00, 32'h0, 1'b0, REG_FIRST, {10{POS_BOTH}}, 1'b0, NO_RES},
			'{ROW_REG, FUNC_SHAPE, 8'h00, 32'h0, 1'b0, REG_SECOND, {10{POS_RIGHT}}, 1'b0,
				NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h43, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h22, POS_RIGHT, 1'b1, 1'b1}},
			'{ROW_REQ, FUNC_SHAPE, 8'h42, 32'h0, 1'b0, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h20, 32'h0, 1'b1, REG_FIRST, '0, 1'b0, NO_RES},
			'{ROW_REQ, FUNC_SHAPE, 8'h41, 32'h0, 1'b1, REG_FIRST, '0, 1'b1,
				'{8'h03, POS_BOTH, 1'b1, 1'b1}}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_REG) begin
				write_reg(row.addr, row.data);
			end else begin
				send_request(row.func, row.code, row.forms, row.eol);
				if (row.known) begin
					check_field("directed glyph_code", row.want.glyph, newest.glyph);
					check_field("directed position", row.want.pos, newest.pos);
					check_field("directed in_table", row.want.in_table, newest.in_table);
					check_field("directed line_last", row.want.last, newest.last);
				end
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin
					rules_a = '0;
					rules_b = '1;
				end
				1: begin
					rules_a = '1;
					rules_b = '0;
				end
				default: begin
					rules_a = random_rules();
					rules_b = random_rules();
				end
			endcase
			write_reg(REG_SECOND, rules_b);
			write_reg(REG_FIRST, rules_a);
			if (seg % 3 == 2)
				write_reg(($urandom_range(0, 1) == 1) ? REG_UNUSED_A : REG_UNUSED_B,
					RULES_W'($urandom()));
			steady = (seg == 4);
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 15) begin
					if ($urandom_range(0, 99) < 60)
						code = {4'h4, 4'($urandom_range(0, 15))};
					else
						code = CODE_W'($urandom_range(0, 255));
					// random loads never use a code ending in F
					if (code[3:0] == 4'hF)
						code[3:0] = 4'hE;
					send_request(FUNC_LOAD, code,
						{random_form(), random_form(), random_form(), random_form()},
						1'($urandom_range(0, 1)));
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 60)
						code = {4'h4, 4'($urandom_range(0, 15))};
					else if (pick < 75)
						code = BLANK_CODE;
					else
						code = CODE_W'($urandom_range(0, 255));
					send_request(FUNC_SHAPE, code, $urandom(), $urandom_range(0, 5) == 0);
				end
			end
			steady = 1'b0;
		end

		// flush the held character
		send_request(FUNC_SHAPE, 8'h41, '0, 1'b1);
		din.valid <= 1'b0;

		while (glyph_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d characters, %0d form loads, %0d register writes",
			n_shaped, n_loads, n_writes);
		$display("compared %0d results, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
